### rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked in every cycle that is not in reset: ante implies cons in the next cycle.
`define BPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpf check failed");

// Checked also across reset: ante implies cons in the next cycle.
`define BPF_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bpf reset check failed");

`endif

### rtl/bpf_pkg.sv
// Types and constants of the bilateral pixel filter.
package bpf_pkg;

  localparam int DEF_RADIUS    = 2;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int RANGE_ENTRIES = 256;
  localparam int MAX_HEIGHT    = 1024;
  localparam int JOB_DEPTH     = 2;
  localparam int OUT_DEPTH     = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_W      = 10;
  localparam int POS_COL_W  = 12;
  localparam int POS_SLOT_W = 4;
  localparam int GEOM_W_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_SPATIAL,
    KIND_RANGE,
    KIND_FLUSH
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value_r;
    logic [15:0] value_g;
    logic [15:0] value_b;
    logic [7:0]  table_index;
    logic [15:0] weight;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_r;
    logic [15:0] out_g;
    logic [15:0] out_b;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
    logic        frame_end;
  } out_word_t;

  // One pending result position, handed from the front to the back.
  typedef struct packed {
    logic [POS_COL_W-1:0]  col;
    logic [ROW_W-1:0]      row;
    logic [POS_SLOT_W-1:0] slot;
    logic                  frame_end;
  } job_t;

  typedef struct packed {
    logic        spatial_we;
    logic        range_we;
    logic [7:0]  index;
    logic [15:0] weight;
  } tbl_wr_t;

  typedef struct packed {
    logic [GEOM_W_W-1:0]   width;
    logic [CFG_DATA_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [1:0] queued;
    logic       back_busy;
  } front_stat_t;

endpackage

### rtl/bilateral_pixel_filter_unit.sv
// Top level of the bilateral pixel filter: front end, job queue, back end, stores.
//
// channel   direction  handshake             word
// --------  ---------  --------------------  ------------------------------------------
// item      in         push / full           kind, r g b (Q8.8), table_index, weight
// result    out        empty / pop           r g b (Q8.8), column, row, frame_end
// config    in         cfg_we (no wait)      cfg_index 0 width, 1 height; cfg_data
//
// In the back end a result passes through job pick-up, one window tap per cycle through the
// row store read port, pipeline drain and a 16-step divider.
// Pixels may run one result ahead of the back end on rows wider than RADIUS; weight table
// writes, the first pixel of a frame and pixels of narrower rows wait until the back end
// and the job queue are empty.
// Flushes drain the last RADIUS rows plus RADIUS pixels after a frame is complete.
// rst is synchronous; the row store and weight tables hold no reset and need no clearing.
// The result queue parts the two sides: a stalled pop blocks the input only once the
// result queue is full and the back end holds a finished word.
module bilateral_pixel_filter_unit #(
  parameter int RADIUS    = bpf_pkg::DEF_RADIUS,
  parameter int MAX_WIDTH = bpf_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  bpf_pkg::in_word_t              item,
  output logic                           empty,
  input  logic                           pop,
  output bpf_pkg::out_word_t             result
);
  import bpf_pkg::*;

  localparam int SPAN     = 2*RADIUS + 1;
  localparam int TAPS     = SPAN*SPAN;
  localparam int SLOTS    = 2*RADIUS + 2;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int STORE_AW = $clog2(SLOTS) + COL_W;
  localparam int SP_AW    = $clog2(TAPS);
  localparam int JCNT_W   = $clog2(JOB_DEPTH+1);
  localparam int OCNT_W   = $clog2(OUT_DEPTH+1);

  front_stat_t         stat;
  job_t                job_in, job_out;
  logic                job_push, job_pop, job_full, job_empty;
  logic [JCNT_W-1:0]   job_count;
  geom_t               geom;
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr, store_raddr;
  logic [47:0]         store_wdata, store_rdata;
  tbl_wr_t             tbl_wr;
  logic [SP_AW-1:0]    sp_raddr;
  logic [15:0]         sp_rdata;
  logic [2:0][7:0]     rg_raddr;
  logic [2:0][15:0]    rg_rdata;
  logic                busy;
  logic                res_push, res_full;
  out_word_t           res;
  logic [$bits(out_word_t)-1:0] out_rdata;
  logic [$bits(job_t)-1:0]      job_rdata;
  logic [OCNT_W-1:0]   out_count;

  // Outstanding work seen by the front end: queued positions plus the one in flight.
  assign stat.queued    = 2'(job_count);
  assign stat.back_busy = busy;

  bpf_front #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .item       (item),
    .stat       (stat),
    .job_push   (job_push),
    .job        (job_in),
    .geom       (geom),
    .store_we   (store_we),
    .store_addr (store_waddr),
    .store_data (store_wdata),
    .tbl_wr     (tbl_wr)
  );

  // Short queue of result positions between front and back.
  bpf_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty),
    .count (job_count)
  );
  assign job_out = job_t'(job_rdata);

  // Row store: SLOTS rows of MAX_WIDTH pixels, addressed {row slot, column}.
  bpf_ram #(.WIDTH(48), .DEPTH(SLOTS << COL_W)) u_row_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  bpf_ram #(.WIDTH(16), .DEPTH(TAPS)) u_spatial (
    .clk   (clk),
    .we    (tbl_wr.spatial_we),
    .waddr (SP_AW'(tbl_wr.index)),
    .wdata (tbl_wr.weight),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  // One copy of the range table per channel, all written together.
  for (genvar c = 0; c < 3; c++) begin : g_range
    bpf_ram #(.WIDTH(16), .DEPTH(RANGE_ENTRIES)) u_range (
      .clk   (clk),
      .we    (tbl_wr.range_we),
      .waddr ($clog2(RANGE_ENTRIES)'(tbl_wr.index)),
      .wdata (tbl_wr.weight),
      .raddr ($clog2(RANGE_ENTRIES)'(rg_raddr[c])),
      .rdata (rg_rdata[c])
    );
  end

  bpf_back #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .job_valid   (!job_empty),
    .job         (job_out),
    .job_pop     (job_pop),
    .busy        (busy),
    .store_raddr (store_raddr),
    .store_rdata (store_rdata),
    .sp_raddr    (sp_raddr),
    .sp_rdata    (sp_rdata),
    .rg_raddr    (rg_raddr),
    .rg_rdata    (rg_rdata),
    .res_push    (res_push),
    .res         (res),
    .res_full    (res_full)
  );

  // Result queue; its head is the word on the result port.
  bpf_fifo #(.WIDTH($bits(out_word_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );
  assign result = out_word_t'(out_rdata);

  // job_full and out_count are kept for visibility; fold them into a harmless check term.
  logic unused_ok;
  assign unused_ok = job_full ^ (out_count == '0);

endmodule

### rtl/bpf_ram.sv
// Generic single write port, single read port RAM with registered read.
module bpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bpf_fifo.sv
// Small register FIFO with occupancy count.
module bpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/bpf_front.sv
// Front end: takes words, writes tables and the row store, schedules result positions.
module bpf_front #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [bpf_pkg::CFG_DATA_W-1:0]                cfg_data,
  input  logic                                          push,
  output logic                                          full,
  input  bpf_pkg::in_word_t                             item,
  input  bpf_pkg::front_stat_t                          stat,
  output logic                                          job_push,
  output bpf_pkg::job_t                                 job,
  output bpf_pkg::geom_t                                geom,
  output logic                                          store_we,
  output logic [$clog2(2*RADIUS+2)+$clog2(MAX_WIDTH)-1:0] store_addr,
  output logic [47:0]                                   store_data,
  output bpf_pkg::tbl_wr_t                              tbl_wr
);
  import bpf_pkg::*;

  localparam int SPAN   = 2*RADIUS + 1;
  localparam int TAPS   = SPAN*SPAN;
  localparam int SLOTS  = 2*RADIUS + 2;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH+1);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int K_W    = $clog2(MAX_WIDTH*MAX_HEIGHT);

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic                  hold_valid;
  in_word_t              hold;
  logic [COL_W-1:0]      in_col,   in_col_next;
  logic [ROW_W-1:0]      in_row,   in_row_next;
  logic [SLOT_W-1:0]     in_slot,  in_slot_next;
  logic [K_W-1:0]        in_k,     in_k_next;
  logic                  in_full,  in_full_next;
  logic [COL_W-1:0]      res_col,  res_col_next;
  logic [ROW_W-1:0]      res_row,  res_row_next;
  logic [SLOT_W-1:0]     res_slot, res_slot_next;

  logic [W_W-1:0]        eff_w;
  logic [CFG_DATA_W-1:0] eff_h;
  logic [K_W-1:0]        lag;
  logic [1:0]            outstanding;
  logic                  restart;
  logic                  narrow;
  logic [COL_W-1:0]      c0, rc0;
  logic [ROW_W-1:0]      r0, rr0;
  logic [SLOT_W-1:0]     s0, rs0;
  logic [K_W-1:0]        k0;
  logic                  go;
  logic                  consume;
  logic                  emit;
  logic                  last_res;
  logic                  cfg_hit;

  always_comb begin
    if (image_width == '0) begin
      eff_w = W_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = CFG_DATA_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_h = CFG_DATA_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  assign lag         = K_W'(RADIUS*int'(eff_w) + RADIUS);
  assign outstanding = stat.queued + {1'b0, stat.back_busy};
  assign geom.width  = GEOM_W_W'(eff_w);
  assign geom.height = eff_h;

  // Rows of RADIUS pixels or fewer: the next pixel lands in a slot the previous window reads.
  assign narrow = (int'(eff_w) <= RADIUS);

  // A position left over from a larger frame starts a new frame.
  assign restart = (int'(in_col) >= int'(eff_w)) || (int'(in_row) >= int'(eff_h));
  assign c0  = restart ? '0 : in_col;
  assign r0  = restart ? '0 : in_row;
  assign s0  = restart ? '0 : in_slot;
  assign k0  = restart ? '0 : in_k;
  assign rc0 = restart ? '0 : res_col;
  assign rr0 = restart ? '0 : res_row;
  assign rs0 = restart ? '0 : res_slot;

  // Pixels may run one result ahead of the back end on rows wider than RADIUS;
  // table writes wait for it to drain.
  always_comb begin
    case (hold.kind)
      KIND_PIXEL:   go = in_full || ((k0 == '0 || narrow) ? (outstanding == 2'd0)
                                                          : (outstanding <= 2'd1));
      KIND_SPATIAL: go = (outstanding == 2'd0);
      KIND_RANGE:   go = (outstanding == 2'd0);
      KIND_FLUSH:   go = !in_full || (int'(stat.queued) < JOB_DEPTH);
      default:      go = 1'b0;
    endcase
  end

  assign consume = hold_valid && go;
  assign full    = hold_valid && !go;
  assign cfg_hit = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

  always_comb begin
    in_col_next   = in_col;
    in_row_next   = in_row;
    in_slot_next  = in_slot;
    in_k_next     = in_k;
    in_full_next  = in_full;
    res_col_next  = res_col;
    res_row_next  = res_row;
    res_slot_next = res_slot;
    emit          = 1'b0;
    store_we      = 1'b0;
    store_addr    = {s0, c0};
    store_data    = {hold.value_b, hold.value_g, hold.value_r};
    tbl_wr.spatial_we = 1'b0;
    tbl_wr.range_we   = 1'b0;
    tbl_wr.index      = hold.table_index;
    tbl_wr.weight     = hold.weight;
    if (consume) begin
      case (hold.kind)
        KIND_SPATIAL: tbl_wr.spatial_we = (int'(hold.table_index) < TAPS);
        KIND_RANGE:   tbl_wr.range_we   = 1'b1;
        KIND_FLUSH:   emit = in_full;
        KIND_PIXEL: begin
          if (!in_full) begin
            store_we      = 1'b1;
            res_col_next  = rc0;
            res_row_next  = rr0;
            res_slot_next = rs0;
            in_k_next     = k0 + 1'b1;
            if ((int'(c0) + 1 >= int'(eff_w)) && (int'(r0) + 1 >= int'(eff_h))) begin
              in_full_next = 1'b1;
              in_col_next  = c0;
              in_row_next  = r0;
              in_slot_next = s0;
            end else if (int'(c0) + 1 >= int'(eff_w)) begin
              in_col_next  = '0;
              in_row_next  = r0 + 1'b1;
              in_slot_next = (s0 == SLOT_W'(SLOTS-1)) ? '0 : s0 + 1'b1;
            end else begin
              in_col_next  = c0 + 1'b1;
              in_row_next  = r0;
              in_slot_next = s0;
            end
            emit = (k0 >= lag);
          end
        end
        default: emit = 1'b0;
      endcase
    end
    // res_*_next already holds the current result position here
    last_res = (int'(res_col_next) + 1 >= int'(eff_w)) &&
               (int'(res_row_next) + 1 >= int'(eff_h));
    job.col       = POS_COL_W'(res_col_next);
    job.row       = res_row_next;
    job.slot      = POS_SLOT_W'(res_slot_next);
    job.frame_end = last_res;
    if (emit) begin
      if (last_res) begin
        in_col_next   = '0;
        in_row_next   = '0;
        in_slot_next  = '0;
        in_k_next     = '0;
        in_full_next  = 1'b0;
        res_col_next  = '0;
        res_row_next  = '0;
        res_slot_next = '0;
      end else if (int'(res_col_next) + 1 >= int'(eff_w)) begin
        res_col_next  = '0;
        res_row_next  = res_row_next + 1'b1;
        res_slot_next = (res_slot_next == SLOT_W'(SLOTS-1)) ? '0 : res_slot_next + 1'b1;
      end else begin
        res_col_next  = res_col_next + 1'b1;
      end
    end
  end

  assign job_push = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      hold_valid   <= 1'b0;
      in_col       <= '0;
      in_row       <= '0;
      in_slot      <= '0;
      in_k         <= '0;
      in_full      <= 1'b0;
      res_col      <= '0;
      res_row      <= '0;
      res_slot     <= '0;
    end else begin
      if (push && !full) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
      if (cfg_hit) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          image_width <= cfg_data;
        end else begin
          image_height <= cfg_data;
        end
        in_col   <= '0;
        in_row   <= '0;
        in_slot  <= '0;
        in_k     <= '0;
        in_full  <= 1'b0;
        res_col  <= '0;
        res_row  <= '0;
        res_slot <= '0;
      end else begin
        in_col   <= in_col_next;
        in_row   <= in_row_next;
        in_slot  <= in_slot_next;
        in_k     <= in_k_next;
        in_full  <= in_full_next;
        res_col  <= res_col_next;
        res_row  <= res_row_next;
        res_slot <= res_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      hold <= item;
    end
  end

endmodule

### rtl/bpf_back.sv
// Back end: walks the window of one position, accumulates, divides, emits a result.
module bpf_back #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  bpf_pkg::geom_t                                  geom,
  input  logic                                            job_valid,
  input  bpf_pkg::job_t                                   job,
  output logic                                            job_pop,
  output logic                                            busy,
  output logic [$clog2(2*RADIUS+2)+$clog2(MAX_WIDTH)-1:0] store_raddr,
  input  logic [47:0]                                     store_rdata,
  output logic [$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0]    sp_raddr,
  input  logic [15:0]                                     sp_rdata,
  output logic [2:0][7:0]                                 rg_raddr,
  input  logic [2:0][15:0]                                rg_rdata,
  output logic                                            res_push,
  output bpf_pkg::out_word_t                              res,
  input  logic                                            res_full
);
  import bpf_pkg::*;

  localparam int SPAN   = 2*RADIUS + 1;
  localparam int TAPS   = SPAN*SPAN;
  localparam int SLOTS  = 2*RADIUS + 2;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IJ_W   = $clog2(SPAN);
  localparam int SP_AW  = $clog2(TAPS);
  localparam int DEN_W  = 16 + $clog2(TAPS);
  localparam int NUM_W  = 32 + $clog2(TAPS);

  typedef enum logic [2:0] {S_IDLE, S_CTR, S_TAP, S_DRAIN, S_DIVI, S_DIV, S_OUT} state_t;

  state_t            state;
  logic [COL_W-1:0]  x;
  logic [ROW_W-1:0]  y;
  logic [SLOT_W-1:0] slot;
  logic              fend;
  logic [IJ_W-1:0]   i, j;
  logic [SP_AW-1:0]  sidx;
  logic              ctr_v;
  logic [47:0]       centre;

  logic              p1_v, p1_in;
  logic              p2_v, p2_in, p3_v, p3_in, p4_v, p4_in;
  logic [15:0]       p2_sw;
  logic [15:0]       p2_vn [3];
  logic [15:0]       p3_wt [3];
  logic [15:0]       p3_vn [3];
  logic [31:0]       p4_prod [3];
  logic [15:0]       p4_wt [3];
  logic [NUM_W-1:0]  num [3];
  logic [DEN_W-1:0]  den [3];
  logic [DEN_W:0]    rem [3];
  logic [15:0]       dlo [3];
  logic [15:0]       quo [3];
  logic [3:0]        dcnt;

  int                pp, qq, ts;
  logic              tap_in;

  // Tap (i,j) is neighbour column x+R-i, row y+R-j.
  always_comb begin
    pp = int'(x) + RADIUS - int'(i);
    qq = int'(y) + RADIUS - int'(j);
    ts = int'(slot) + SLOTS + RADIUS - int'(j);
    if (ts >= SLOTS) begin
      ts = ts - SLOTS;
    end
    if (ts >= SLOTS) begin
      ts = ts - SLOTS;
    end
    tap_in = (pp >= 0) && (pp < int'(geom.width)) && (qq >= 0) && (qq < int'(geom.height));
    if (state == S_TAP) begin
      store_raddr = {SLOT_W'(ts), COL_W'(pp)};
    end else begin
      store_raddr = {slot, x};
    end
  end

  assign sp_raddr = sidx;
  assign busy     = (state != S_IDLE);
  assign job_pop  = (state == S_IDLE) && job_valid;
  assign res_push = (state == S_OUT) && !res_full;

  // Range index per channel: integer part of the absolute difference to the centre.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [15:0] vn, vc, d;
      vn = store_rdata[16*c +: 16];
      vc = centre[16*c +: 16];
      d  = (vn >= vc) ? vn - vc : vc - vn;
      rg_raddr[c] = d[15:8];
    end
  end

  assign res.out_r     = (den[0] == '0) ? centre[15:0]  : quo[0];
  assign res.out_g     = (den[1] == '0) ? centre[31:16] : quo[1];
  assign res.out_b     = (den[2] == '0) ? centre[47:32] : quo[2];
  assign res.out_col   = 10'(x);
  assign res.out_row   = y;
  assign res.frame_end = fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctr_v <= 1'b0;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      p3_v  <= 1'b0;
      p4_v  <= 1'b0;
    end else begin
      ctr_v <= (state == S_CTR);
      p1_v  <= (state == S_TAP);
      p2_v  <= p1_v;
      p3_v  <= p2_v;
      p4_v  <= p3_v;
      case (state)
        S_IDLE:  if (job_valid) state <= S_CTR;
        S_CTR:   state <= S_TAP;
        S_TAP:   if (sidx == SP_AW'(TAPS-1)) state <= S_DRAIN;
        S_DRAIN: if (!p1_v && !p2_v && !p3_v && !p4_v) state <= S_DIVI;
        S_DIVI:  state <= S_DIV;
        S_DIV:   if (dcnt == 4'd15) state <= S_OUT;
        S_OUT:   if (!res_full) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W:0]   dsum;
    logic [DEN_W+1:0] t;
    logic [31:0]      wfull;
    if (state == S_IDLE && job_valid) begin
      x    <= COL_W'(job.col);
      y    <= job.row;
      slot <= SLOT_W'(job.slot);
      fend <= job.frame_end;
    end
    if (state == S_CTR) begin
      i    <= '0;
      j    <= '0;
      sidx <= '0;
    end else if (state == S_TAP) begin
      sidx <= sidx + 1'b1;
      if (j == IJ_W'(SPAN-1)) begin
        j <= '0;
        i <= i + 1'b1;
      end else begin
        j <= j + 1'b1;
      end
    end
    if (ctr_v) begin
      centre <= store_rdata;
    end
    p1_in <= tap_in;
    p2_in <= p1_in;
    p3_in <= p2_in;
    p4_in <= p3_in;
    p2_sw <= sp_rdata;
    for (int c = 0; c < 3; c++) begin
      p2_vn[c]   <= store_rdata[16*c +: 16];
      wfull       = 32'(p2_sw) * 32'(rg_rdata[c]);
      p3_wt[c]   <= wfull[31:16];
      p3_vn[c]   <= p2_vn[c];
      p4_prod[c] <= 32'(p3_wt[c]) * 32'(p3_vn[c]);
      p4_wt[c]   <= p3_wt[c];
      if (state == S_IDLE) begin
        num[c] <= '0;
        den[c] <= '0;
      end else if (p4_v && p4_in) begin
        num[c] <= num[c] + NUM_W'(p4_prod[c]);
        den[c] <= den[c] + DEN_W'(p4_wt[c]);
      end
      // Rounded quotient fits 16 bits, so the top of the dividend starts below den.
      if (state == S_DIVI) begin
        dsum   = (NUM_W+1)'(num[c]) + (NUM_W+1)'(den[c] >> 1);
        rem[c] <= (DEN_W+1)'(dsum >> 16);
        dlo[c] <= dsum[15:0];
        quo[c] <= '0;
      end else if (state == S_DIV) begin
        t = {rem[c], dlo[c][15]};
        if (t >= (DEN_W+2)'(den[c])) begin
          rem[c] <= (DEN_W+1)'(t - (DEN_W+2)'(den[c]));
          quo[c] <= {quo[c][14:0], 1'b1};
        end else begin
          rem[c] <= t[DEN_W:0];
          quo[c] <= {quo[c][14:0], 1'b0};
        end
        dlo[c] <= {dlo[c][14:0], 1'b0};
      end
    end
    if (state == S_DIVI) begin
      dcnt <= '0;
    end else if (state == S_DIV) begin
      dcnt <= dcnt + 1'b1;
    end
  end

endmodule

### rtl/bpf_checker.sv
// Port-level checks of the bilateral pixel filter, bound to its top level.
`include "assert_macros.svh"

module bpf_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input bpf_pkg::out_word_t result
);
  import bpf_pkg::*;

  // Reset leaves both queues open and empty.
  `BPF_ASSERT_ALWAYS(a_reset_state, rst, empty && !full)
  // A waiting result word holds until it is taken.
  `BPF_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result))
  // No result can come out straight after reset release.
  `BPF_ASSERT_NEXT(a_no_early_result, $past(rst), empty)

endmodule

bind bilateral_pixel_filter_unit bpf_checker u_bpf_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);

### test/bilateral_pixel_filter_unit_test.sv
// Self-checking regression bench for the bilateral pixel filter unit.
module bilateral_pixel_filter_unit_test;
  import bpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD   = DEF_RADIUS;
  localparam int SPAN  = 2 * RAD + 1;
  localparam int TAPS  = SPAN * SPAN;
  localparam int SLOTS = 2 * RAD + 2;
  localparam int MAXW  = DEF_MAX_WIDTH;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // not a register
  localparam int ITEM_GOAL = 1850;

  // Scoreboard: own model of the filter plus the queue of expected words.
  class filter_scoreboard;
    logic [47:0] rows [SLOTS*MAXW];
    logic [15:0] spatial [TAPS];
    logic [15:0] rangew [RANGE_ENTRIES];
    int unsigned in_col, in_row, res_col, res_row;
    bit          frame_in;
    int unsigned reg_w, reg_h;
    out_word_t   awaited [$];
    int          errors;

    function new();
      reg_w = RST_IMAGE_WIDTH;
      reg_h = RST_IMAGE_HEIGHT;
      restart();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; res_col = 0; res_row = 0; frame_in = 0;
    endfunction

    function int unsigned eff_w();
      return reg_w < 1 ? 1 : (reg_w > MAXW ? MAXW : reg_w);
    endfunction

    function int unsigned eff_h();
      return reg_h < 1 ? 1 : (reg_h > MAX_HEIGHT ? MAX_HEIGHT : reg_h);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_IMAGE_WIDTH) reg_w = d;
      else if (idx == CFG_IMAGE_HEIGHT) reg_h = d;
      else return;
      restart();
    endfunction

    // Filter the pixel at the result position and advance it.
    function void filter_next();
      int unsigned w, h, sw, rw, vn, vc, diff;
      int x, y;
      logic [47:0] ctr, nb;
      longint unsigned num [3], den [3], wt;
      out_word_t o;
      w = eff_w(); h = eff_h();
      x = res_col; y = res_row;
      ctr = rows[(res_row % SLOTS) * MAXW + res_col];
      for (int c = 0; c < 3; c++) begin
        num[c] = 0; den[c] = 0;
      end
      for (int p = x - RAD; p <= x + RAD; p++) begin
        if (p < 0 || p >= int'(w)) continue;
        for (int q = y - RAD; q <= y + RAD; q++) begin
          if (q < 0 || q >= int'(h)) continue;
          nb = rows[(q % SLOTS) * MAXW + p];
          sw = spatial[(x - p + RAD) * SPAN + (y - q + RAD)];
          for (int c = 0; c < 3; c++) begin
            vn = nb[16*c +: 16];
            vc = ctr[16*c +: 16];
            diff = vn >= vc ? vn - vc : vc - vn;
            rw = rangew[(diff >> 8) & 8'hFF];
            wt = (longint'(sw) * rw) >> 16;
            num[c] += wt * vn;
            den[c] += wt;
          end
        end
      end
      o.out_r = den[0] == 0 ? ctr[15:0]  : 16'((num[0] + den[0] / 2) / den[0]);
      o.out_g = den[1] == 0 ? ctr[31:16] : 16'((num[1] + den[1] / 2) / den[1]);
      o.out_b = den[2] == 0 ? ctr[47:32] : 16'((num[2] + den[2] / 2) / den[2]);
      o.out_col = res_col[9:0];
      o.out_row = res_row[9:0];
      o.frame_end = (res_col + 1 >= w && res_row + 1 >= h);
      awaited.push_back(o);
      if (o.frame_end) begin
        restart();
      end else begin
        res_col++;
        if (res_col >= w) begin
          res_col = 0; res_row++;
        end
      end
    endfunction

    // Accepted input word.
    function void note_word(in_word_t it);
      int unsigned w, h, k, lag;
      w = eff_w(); h = eff_h();
      case (it.kind)
        KIND_SPATIAL: if (it.table_index < TAPS) spatial[it.table_index] = it.weight;
        KIND_RANGE:   rangew[it.table_index] = it.weight;
        KIND_FLUSH:   if (frame_in) filter_next();
        default: begin
          if (!frame_in) begin
            if (in_col >= w || in_row >= h) restart();
            rows[(in_row % SLOTS) * MAXW + in_col] = {it.value_b, it.value_g, it.value_r};
            k = in_row * w + in_col;
            lag = RAD * w + RAD;
            if (in_col + 1 >= w && in_row + 1 >= h) begin
              frame_in = 1;
            end else begin
              in_col++;
              if (in_col >= w) begin
                in_col = 0; in_row++;
              end
            end
            if (k >= lag) filter_next();
          end
        end
      endcase
    endfunction

    // Accepted result word against the oldest expectation.
    function void check_word(out_word_t got);
      out_word_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result word col %0d row %0d", got.out_col, got.out_row);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.out_r !== e.out_r) begin
        $error("out_r exp %h got %h", e.out_r, got.out_r); errors++;
      end
      if (got.out_g !== e.out_g) begin
        $error("out_g exp %h got %h", e.out_g, got.out_g); errors++;
      end
      if (got.out_b !== e.out_b) begin
        $error("out_b exp %h got %h", e.out_b, got.out_b); errors++;
      end
      if (got.out_col !== e.out_col) begin
        $error("out_col exp %0d got %0d", e.out_col, got.out_col); errors++;
      end
      if (got.out_row !== e.out_row) begin
        $error("out_row exp %0d got %0d", e.out_row, got.out_row); errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $error("frame_end exp %0d got %0d", e.frame_end, got.frame_end); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic push, full, empty, pop;
  in_word_t  item;
  out_word_t result;

  filter_scoreboard sb;
  int  words_sent;
  bit  calm;        // no idling on either side while set
  int  hold_req;    // receiver stall length requested by the sender

  bilateral_pixel_filter_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #20ms;
    $display("bilateral_pixel_filter_unit regression: fail");
    $finish;
  end

  // Send one word; full only moves on rising edges, so the value seen at the
  // falling edge is the one the next rising edge uses.
  task automatic send_word(in_word_t w);
    bit ok;
    while (!calm && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    do begin
      @(negedge clk);
      ok = !full;
      @(posedge clk);
    end while (!ok);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_kind(kind_t k, logic [7:0] idx = '0, logic [15:0] wt = '0,
                           logic [47:0] rgb = '0);
    in_word_t w;
    w = $bits(in_word_t)'({$urandom, $urandom, $urandom});  // unused fields carry noise
    w.kind = k;
    if (k == KIND_PIXEL) begin
      {w.value_b, w.value_g, w.value_r} = rgb;
    end else if (k != KIND_FLUSH) begin
      w.table_index = idx;
      w.weight = wt;
    end
    send_word(w);
  endtask

  // Drain, then give the back end time to finish work that yields no word.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic load_spatial(bit zero);
    for (int i = 0; i < TAPS; i++)
      send_kind(KIND_SPATIAL, 8'(i), zero ? 16'h0 : 16'($urandom_range(16'hFFFF, 16'h1000)));
  endtask

  function automatic logic [47:0] pick_pixel(logic [47:0] prev);
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    if ($urandom_range(99) < 40) begin
      // near the previous pixel so that small range indices dominate
      v[15:0]  = prev[15:0]  + 16'($urandom_range(1023));
      v[31:16] = prev[31:16] - 16'($urandom_range(1023));
      v[47:32] = prev[47:32] ^ 16'($urandom_range(511));
    end
    return v;
  endfunction

  // One whole frame of pixels plus noise, then flushes until drained.
  task automatic run_frame();
    int unsigned n;
    logic [47:0] px;
    px = '0;
    n = sb.eff_w() * sb.eff_h();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) send_kind(KIND_FLUSH);  // frame not complete yet
      if ($urandom_range(99) < 3)
        send_kind(KIND_RANGE, 8'($urandom), 16'($urandom));
      if ($urandom_range(99) < 2)
        send_kind(KIND_SPATIAL, 8'($urandom_range(255, TAPS)), 16'($urandom));
      px = pick_pixel(px);
      send_kind(KIND_PIXEL, '0, '0, px);
      if (words_sent > 300 && hold_req == 0) hold_req = 400;
    end
    if ($urandom_range(3) == 0) send_kind(KIND_PIXEL, '0, '0, 48'({$urandom, $urandom}));
    while (sb.frame_in) send_kind(KIND_FLUSH);
  endtask

  // Receiver: checks each popped word, stalls at random.
  initial begin : receiver
    bit          e, p;
    out_word_t   r;
    int          held;
    held = 0;
    forever begin
      @(negedge clk);
      e = empty;
      r = result;
      p = pop;
      @(posedge clk);
      if (!rst && p && !e) sb.check_word(r);
      if (hold_req > 0 && held == 0) begin
        held = hold_req;
        hold_req = -1;  // only once
      end
      if (held > 0) begin
        held--;
        pop <= 1'b0;
      end else begin
        pop <= calm || $urandom_range(99) >= 23;
      end
    end
  end

  initial begin : stimulus
    logic [47:0] px;
    sb = new();
    words_sent = 0;
    calm = 0;
    hold_req = 0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every table entry written before any filtering reads it
    load_spatial(0);
    for (int i = 0; i < RANGE_ENTRIES; i++)
      send_kind(KIND_RANGE, 8'(i), i == 7 ? 16'h0 : (i == 9 ? 16'hFFFF : 16'($urandom)));
    send_kind(KIND_SPATIAL, 8'hFF, 16'hFFFF);  // past the spatial table: dropped

    // reset geometry: lag is longer than these pixels, so no words
    send_kind(KIND_FLUSH);
    send_kind(KIND_PIXEL, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_kind(KIND_PIXEL, '0, '0, 48'h0);
    settle();

    // width below range, height above range: one column, tall
    write_reg(CFG_IMAGE_WIDTH, 11'd0);
    write_reg(CFG_IMAGE_HEIGHT, 11'h7FF);
    for (int i = 0; i < 10; i++)
      send_kind(KIND_PIXEL, '0, '0, i[0] ? 48'hFFFF_FFFF_FFFF : 48'h0);
    settle();

    // widest row, single row: stays below the lag
    write_reg(CFG_IMAGE_WIDTH, 11'h7FF);
    write_reg(CFG_IMAGE_HEIGHT, 11'd0);
    for (int i = 0; i < 6; i++) send_kind(KIND_PIXEL, '0, '0, 48'({$urandom, $urandom}));
    settle();

    // 1x1 frame, spare register index is a no-op
    write_reg(CFG_IMAGE_WIDTH, 11'd1);
    write_reg(CFG_IMAGE_HEIGHT, 11'd1);
    write_reg(CFG_SPARE, 11'd5);
    run_frame();
    settle();

    // random frames, small geometry mostly
    while (words_sent < ITEM_GOAL) begin
      calm = words_sent > 900 && words_sent < 1200;
      write_reg(CFG_IMAGE_WIDTH, $urandom_range(9) == 0 ? 11'($urandom_range(40, 1)) :
                                 11'($urandom_range(8, 1)));
      write_reg(CFG_IMAGE_HEIGHT, 11'($urandom_range(6, 1)));
      if ($urandom_range(11) == 0) begin
        load_spatial(1);  // zero weights everywhere: centre passes through
        run_frame();
        load_spatial(0);
      end else begin
        run_frame();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("bilateral_pixel_filter_unit regression: pass");
    end else begin
      $display("bilateral_pixel_filter_unit regression: fail");
    end
    $finish;
  end
endmodule
